>>> hw/rtl/iff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, character codes and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int DIGIT_STORE_DEF = 64;   // digit slots kept by the converter
    localparam int DEC_DIGITS      = 20;   // BCD digits needed for 64 bits
    localparam int OUT_CNT_W       = 7;    // a field holds at most 64 chars
    localparam int FW_W            = 6;
    localparam logic [FW_W-1:0] WIDTH_LIMIT = 6'd62;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UA    = 7'h41;
    localparam logic [6:0] CH_UX    = 7'h58;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_LX    = 7'h78;

    typedef enum logic [2:0] {
        OP_SDEC = 3'd0,
        OP_UDEC = 3'd1,
        OP_HEXL = 3'd2,
        OP_HEXU = 3'd3,
        OP_PTR  = 3'd4,
        OP_OCT  = 3'd5,
        OP_BIN  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_HEX,
        RDX_OCT,
        RDX_BIN
    } radix_t;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_POW2,
        CV_DEC,
        CV_TRIM,
        CV_DONE
    } conv_state_t;

    typedef enum logic [3:0] {
        EM_IDLE,
        EM_CONV,
        EM_SETUP,
        EM_LPAD,
        EM_SIGN,
        EM_PFX0,
        EM_PFXX,
        EM_ZPAD,
        EM_DIG,
        EM_RPAD
    } emit_state_t;

    // per-request formatting info, held while the field is produced
    typedef struct packed {
        logic            caps;
        logic            prefix;
        logic            has_sign;
        logic [6:0]      sign_ch;
        logic            flag_left;
        logic            flag_zero;
        logic [FW_W-1:0] width;
    } fmt_req_t;

    function automatic logic [6:0] to_ascii(input logic [3:0] d, input logic caps);
        logic [6:0] dv;
        logic [6:0] r;
        dv = {3'b000, d};
        if (d < 4'd10) begin
            r = CH_ZERO + dv;
        end else begin
            r = (caps ? CH_UA : CH_LA) + dv - 7'd10;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/integer_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats one integer conversion request as a printf-style ASCII field,
// one character per output beat, with tlast on the final character.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser | tlast
//  s_      | in  | value, wide, left/plus/space/zero/alt,  | op    | -
//          |     | min_width                              |       |
//  m_      | out | char_out                               | -     | last
//
// One request at a time. After acceptance the converter peels the digits for
// hex, octal and binary, or shifts in the 32/64 value bits (narrow/wide) and
// then trims leading zeros for decimal; a handoff state and a setup state
// follow, then the characters go out one per beat (up to 64). The next
// request is taken the cycle after the last character goes out. A kind code
// of 7 is taken and dropped. Stalls on m_tready simply hold the current
// character.
// Synchronous active-low reset clears the sequencer states only.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
    parameter int DIGIT_STORE = iff_pkg::DIGIT_STORE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] value, [64] wide, [65] flag_left, [66] flag_plus, [67] flag_space,
    // [68] flag_zero, [69] flag_alt, [75:70] min_width, [79:76] zero
    input  logic [79:0] s_tdata,
    // [2:0] op
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] char_out, [7] zero
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    localparam int NDW = $clog2(DIGIT_STORE + 1);

    logic [63:0]       value;
    logic              wide, f_left, f_plus, f_space, f_zero, f_alt;
    logic [5:0]        fw;
    iff_pkg::op_t      op;

    logic              accept, start, op_ok, caps, is_sdec, alt_ok;
    iff_pkg::radix_t   radix;
    logic              neg;
    logic [63:0]       sval, mag;

    iff_pkg::fmt_req_t req_reg, req_next;

    logic              em_idle, shift_out, conv_done;
    logic [NDW-1:0]    nd;
    logic [3:0]        top_digit;
    logic [6:0]        m_char;

    assign value   = s_tdata[63:0];
    assign wide    = s_tdata[64];
    assign f_left  = s_tdata[65];
    assign f_plus  = s_tdata[66];
    assign f_space = s_tdata[67];
    assign f_zero  = s_tdata[68];
    assign f_alt   = s_tdata[69];
    assign fw      = s_tdata[75:70];
    assign op      = iff_pkg::op_t'(s_tuser);

    always_comb begin
        op_ok   = 1'b1;
        caps    = 1'b0;
        is_sdec = 1'b0;
        alt_ok  = 1'b0;
        radix   = iff_pkg::RDX_HEX;
        unique case (op)
            iff_pkg::OP_SDEC: begin
                radix   = iff_pkg::RDX_DEC;
                is_sdec = 1'b1;
            end
            iff_pkg::OP_UDEC: radix = iff_pkg::RDX_DEC;
            iff_pkg::OP_HEXL: alt_ok = 1'b1;
            iff_pkg::OP_HEXU: begin
                caps   = 1'b1;
                alt_ok = 1'b1;
            end
            iff_pkg::OP_PTR:  caps  = 1'b1;
            iff_pkg::OP_OCT:  radix = iff_pkg::RDX_OCT;
            iff_pkg::OP_BIN:  radix = iff_pkg::RDX_BIN;
            default:          op_ok = 1'b0;
        endcase
    end

    // magnitude: narrow signed values are sign-extended before negation
    always_comb begin
        neg  = is_sdec && (wide ? value[63] : value[31]);
        sval = wide ? value
                    : (is_sdec ? {{32{value[31]}}, value[31:0]} : {32'd0, value[31:0]});
        mag  = neg ? (64'd0 - sval) : sval;
    end

    always_comb begin
        req_next = req_reg;
        if (accept) begin
            req_next.caps      = caps;
            req_next.prefix    = alt_ok && f_alt;
            req_next.has_sign  = is_sdec && (neg || f_plus || f_space);
            req_next.sign_ch   = neg ? iff_pkg::CH_MINUS
                               : (f_plus ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE);
            req_next.flag_left = f_left;
            req_next.flag_zero = f_zero;
            req_next.width     = (fw > iff_pkg::WIDTH_LIMIT) ? iff_pkg::WIDTH_LIMIT : fw;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    assign s_tready = em_idle;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && op_ok;

    iff_conv #(
        .DIGIT_STORE (DIGIT_STORE)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .mag       (mag),
        .radix     (radix),
        .wide      (wide),
        .shift_out (shift_out),
        .done      (conv_done),
        .nd        (nd),
        .top_digit (top_digit)
    );

    iff_emit #(
        .DIGIT_STORE (DIGIT_STORE)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req_reg),
        .conv_done (conv_done),
        .nd        (nd),
        .top_digit (top_digit),
        .m_ready   (m_tready),
        .idle      (em_idle),
        .shift_out (shift_out),
        .m_valid   (m_tvalid),
        .m_char    (m_char),
        .m_last    (m_tlast)
    );

    assign m_tdata = {1'b0, m_char};

endmodule

>>> hw/rtl/iff_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_conv
// Digit converter: peels power-of-two digits one per cycle, or runs a
// bit-serial double-dabble for decimal, into a digit shift register that
// holds the most significant digit at the top.
// ----------------------------------------------------------------------------
module iff_conv #(
    parameter int DIGIT_STORE = iff_pkg::DIGIT_STORE_DEF,
    localparam int NDW = $clog2(DIGIT_STORE + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          mag,
    input  iff_pkg::radix_t      radix,
    input  logic                 wide,
    input  logic                 shift_out,
    output logic                 done,
    output logic [NDW-1:0]       nd,
    output logic [3:0]           top_digit
);

    localparam int DW = DIGIT_STORE * 4;
    localparam int BW = iff_pkg::DEC_DIGITS * 4;

    iff_pkg::conv_state_t state_reg, state_next;
    iff_pkg::radix_t      radix_reg, radix_next;
    logic [63:0]          val_reg, val_next;
    logic [DW-1:0]        dig_reg, dig_next;
    logic [NDW-1:0]       nd_reg, nd_next;
    logic [6:0]           bits_reg, bits_next;

    logic [3:0]           p2_digit;
    logic [63:0]          val_sh;
    logic [BW-1:0]        bcd;
    logic [BW-1:0]        adj;
    logic                 trim_more;

    // low digit and remaining value for the power-of-two radixes
    always_comb begin
        unique case (radix_reg)
            iff_pkg::RDX_BIN: begin
                p2_digit = {3'b000, val_reg[0]};
                val_sh   = val_reg >> 1;
            end
            iff_pkg::RDX_OCT: begin
                p2_digit = {1'b0, val_reg[2:0]};
                val_sh   = val_reg >> 3;
            end
            default: begin
                p2_digit = val_reg[3:0];
                val_sh   = val_reg >> 4;
            end
        endcase
    end

    // add-3 correction on every BCD digit before the next shift
    always_comb begin
        bcd = dig_reg[DW-1 -: BW];
        for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
        end
    end

    assign trim_more = (dig_reg[DW-1 -: 4] == 4'd0) && (nd_reg > NDW'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iff_pkg::CV_IDLE, iff_pkg::CV_DONE: begin
                if (start) begin
                    state_next = (radix == iff_pkg::RDX_DEC) ? iff_pkg::CV_DEC
                                                             : iff_pkg::CV_POW2;
                end
            end
            iff_pkg::CV_POW2: begin
                if ((val_sh == 64'd0) || (nd_reg == NDW'(DIGIT_STORE - 1))) begin
                    state_next = iff_pkg::CV_DONE;
                end
            end
            iff_pkg::CV_DEC: begin
                if (bits_reg == 7'd1) begin
                    state_next = iff_pkg::CV_TRIM;
                end
            end
            iff_pkg::CV_TRIM: begin
                if (!trim_more) begin
                    state_next = iff_pkg::CV_DONE;
                end
            end
            default: state_next = iff_pkg::CV_IDLE;
        endcase
    end

    always_comb begin
        radix_next = radix_reg;
        val_next   = val_reg;
        dig_next   = dig_reg;
        nd_next    = nd_reg;
        bits_next  = bits_reg;
        if (start) begin
            radix_next = radix;
            // narrow decimal: move the 32 bits up so the MSB shifts out first
            val_next   = ((radix == iff_pkg::RDX_DEC) && !wide) ? {mag[31:0], 32'd0} : mag;
            dig_next   = '0;
            nd_next    = '0;
            bits_next  = wide ? 7'd64 : 7'd32;
        end else begin
            case (state_reg)
                iff_pkg::CV_POW2: begin
                    dig_next = {p2_digit, dig_reg[DW-1:4]};
                    val_next = val_sh;
                    nd_next  = nd_reg + NDW'(1);
                end
                iff_pkg::CV_DEC: begin
                    dig_next[DW-1 -: BW] = {adj[BW-2:0], val_reg[63]};
                    val_next  = val_reg << 1;
                    bits_next = bits_reg - 7'd1;
                    if (bits_reg == 7'd1) begin
                        nd_next = NDW'(iff_pkg::DEC_DIGITS);
                    end
                end
                iff_pkg::CV_TRIM: begin
                    if (trim_more) begin
                        dig_next = dig_reg << 4;
                        nd_next  = nd_reg - NDW'(1);
                    end
                end
                iff_pkg::CV_DONE: begin
                    if (shift_out) begin
                        dig_next = dig_reg << 4;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iff_pkg::CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        radix_reg <= radix_next;
        val_reg   <= val_next;
        dig_reg   <= dig_next;
        nd_reg    <= nd_next;
        bits_reg  <= bits_next;
    end

    assign done      = (state_reg == iff_pkg::CV_DONE);
    assign nd        = nd_reg;
    assign top_digit = dig_reg[DW-1 -: 4];

endmodule

>>> hw/rtl/iff_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_emit
// Field sequencer: sizes the padding, then walks the field segments and
// sends one character per cycle while m_ready takes it, marking the last one.
// ----------------------------------------------------------------------------
module iff_emit #(
    parameter int DIGIT_STORE = iff_pkg::DIGIT_STORE_DEF,
    localparam int NDW = $clog2(DIGIT_STORE + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  iff_pkg::fmt_req_t    req,
    input  logic                 conv_done,
    input  logic [NDW-1:0]       nd,
    input  logic [3:0]           top_digit,
    input  logic                 m_ready,
    output logic                 idle,
    output logic                 shift_out,
    output logic                 m_valid,
    output logic [6:0]           m_char,
    output logic                 m_last
);

    localparam int CW = iff_pkg::OUT_CNT_W;

    iff_pkg::emit_state_t state_reg, state_next;
    logic [CW-1:0]        run_reg, run_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [iff_pkg::FW_W-1:0] pad_reg, pad_next;

    logic [CW-1:0]        nd_ext;
    logic [CW-1:0]        pfx_cnt;
    logic [CW-1:0]        counted;
    logic [CW-1:0]        wid_ext;
    logic [iff_pkg::FW_W-1:0] pad_calc;
    logic [iff_pkg::FW_W-1:0] pad_val;
    logic [CW-1:0]        total;
    logic                 lpad_ne, zpad_ne, rpad_ne;
    logic                 hs, run_end;
    iff_pkg::emit_state_t after_setup, after_lpad, after_sign, after_pfx;

    assign nd_ext  = CW'(nd);
    assign pfx_cnt = req.prefix ? CW'(2) : CW'(0);
    // prefix counts toward the width only under space padding
    assign counted = nd_ext + CW'(req.has_sign) + (req.flag_zero ? CW'(0) : pfx_cnt);
    assign wid_ext = CW'(req.width);
    assign pad_calc = (wid_ext > counted) ? iff_pkg::FW_W'(wid_ext - counted) : '0;
    assign pad_val  = (state_reg == iff_pkg::EM_SETUP) ? pad_calc : pad_reg;
    assign total    = CW'(pad_val) + nd_ext + CW'(req.has_sign) + pfx_cnt;

    assign lpad_ne = !req.flag_zero && !req.flag_left && (pad_val != '0);
    assign zpad_ne =  req.flag_zero && (pad_val != '0);
    assign rpad_ne = !req.flag_zero &&  req.flag_left && (pad_val != '0);

    assign after_pfx   = zpad_ne ? iff_pkg::EM_ZPAD : iff_pkg::EM_DIG;
    assign after_sign  = req.prefix ? iff_pkg::EM_PFX0 : after_pfx;
    assign after_lpad  = req.has_sign ? iff_pkg::EM_SIGN : after_sign;
    assign after_setup = lpad_ne ? iff_pkg::EM_LPAD : after_lpad;

    assign hs      = m_valid && m_ready;
    assign run_end = (run_reg == CW'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iff_pkg::EM_IDLE:  if (start) state_next = iff_pkg::EM_CONV;
            iff_pkg::EM_CONV:  if (conv_done) state_next = iff_pkg::EM_SETUP;
            iff_pkg::EM_SETUP: state_next = after_setup;
            iff_pkg::EM_LPAD:  if (hs && run_end) state_next = after_lpad;
            iff_pkg::EM_SIGN:  if (hs) state_next = after_sign;
            iff_pkg::EM_PFX0:  if (hs) state_next = iff_pkg::EM_PFXX;
            iff_pkg::EM_PFXX:  if (hs) state_next = after_pfx;
            iff_pkg::EM_ZPAD:  if (hs && run_end) state_next = iff_pkg::EM_DIG;
            iff_pkg::EM_DIG: begin
                if (hs && run_end) begin
                    state_next = rpad_ne ? iff_pkg::EM_RPAD : iff_pkg::EM_IDLE;
                end
            end
            iff_pkg::EM_RPAD:  if (hs && run_end) state_next = iff_pkg::EM_IDLE;
            default:           state_next = iff_pkg::EM_IDLE;
        endcase
    end

    always_comb begin
        pad_next = pad_reg;
        rem_next = rem_reg;
        run_next = run_reg;
        if (state_reg == iff_pkg::EM_SETUP) begin
            pad_next = pad_calc;
            rem_next = total;
        end else if (hs) begin
            rem_next = rem_reg - CW'(1);
        end
        // run length loads on entry to a segment
        if (state_next != state_reg) begin
            run_next = (state_next == iff_pkg::EM_DIG) ? nd_ext : CW'(pad_val);
        end else if (hs) begin
            run_next = run_reg - CW'(1);
        end
    end

    always_comb begin
        m_valid = 1'b1;
        m_char  = iff_pkg::CH_SPACE;
        unique case (state_reg)
            iff_pkg::EM_LPAD, iff_pkg::EM_RPAD: m_char = iff_pkg::CH_SPACE;
            iff_pkg::EM_SIGN:  m_char = req.sign_ch;
            iff_pkg::EM_PFX0, iff_pkg::EM_ZPAD: m_char = iff_pkg::CH_ZERO;
            iff_pkg::EM_PFXX:  m_char = req.caps ? iff_pkg::CH_UX : iff_pkg::CH_LX;
            iff_pkg::EM_DIG:   m_char = iff_pkg::to_ascii(top_digit, req.caps);
            default:           m_valid = 1'b0;
        endcase
    end

    assign m_last    = (rem_reg == CW'(1));
    assign shift_out = hs && (state_reg == iff_pkg::EM_DIG);
    assign idle      = (state_reg == iff_pkg::EM_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iff_pkg::EM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg <= pad_next;
        rem_reg <= rem_next;
        run_reg <= run_next;
    end

endmodule

>>> dv/iff_char_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_char_checker
// Watches both channels of the integer field formatter. Each accepted request
// is formatted here into its expected characters. Each character that comes
// out is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module iff_char_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [63:0] value, [64] wide, [65] flag_left, [66] flag_plus, [67] flag_space,
    // [68] flag_zero, [69] flag_alt, [75:70] min_width, [79:76] zero
    input  logic [79:0] s_tdata,
    // [2:0] op
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] char_out, [7] zero
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          error_count,
    output int          pend_cnt
);
    import iff_pkg::*;

    localparam logic [2:0] OP_UNDEF   = 3'd7;   // kind code the block drops
    localparam int         FIELD_MAX  = 64;
    localparam int         REPORT_MAX = 10;

    logic [7:0] char_q [$];                     // {last, char}
    logic [6:0] field_buf [0:FIELD_MAX-1];
    int         field_len;
    logic [7:0] want;

    task automatic put_char(input logic [6:0] ch);
        if (field_len < FIELD_MAX) begin
            field_buf[field_len] = ch;
            field_len++;
        end
    endtask

    task automatic format_field(input logic [2:0] kind, input logic [79:0] req);
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic        wide, f_left, f_plus, f_space, f_zero, f_alt;
        logic        caps, prefix, has_sign;
        logic [6:0]  sign_ch;
        logic [6:0]  digs [0:DIGIT_STORE_DEF-1];
        int          nd, lim, counted, padn;

        mag     = req[63:0];
        wide    = req[64];
        f_left  = req[65];
        f_plus  = req[66];
        f_space = req[67];
        f_zero  = req[68];
        f_alt   = req[69];
        lim     = (req[75:70] > WIDTH_LIMIT) ? WIDTH_LIMIT : req[75:70];
        caps    = (kind == OP_HEXU) || (kind == OP_PTR);
        prefix  = ((kind == OP_HEXL) || (kind == OP_HEXU)) && f_alt;
        has_sign = 1'b0;
        sign_ch  = CH_SPACE;

        if (!wide) mag = {32'd0, mag[31:0]};
        if (kind == OP_SDEC) begin
            if (wide ? mag[63] : mag[31]) begin
                if (!wide) mag[63:32] = '1;
                mag      = -mag;
                has_sign = 1'b1;
                sign_ch  = CH_MINUS;
            end else if (f_plus) begin
                has_sign = 1'b1;
                sign_ch  = CH_PLUS;
            end else if (f_space) begin
                has_sign = 1'b1;
                sign_ch  = CH_SPACE;
            end
        end

        case (kind)
            OP_SDEC, OP_UDEC: base = 64'd10;
            OP_OCT:           base = 64'd8;
            OP_BIN:           base = 64'd2;
            default:          base = 64'd16;
        endcase

        // least significant digit first
        nd = 0;
        do begin
            d = mag % base;
            if (d < 64'd10) digs[nd] = CH_ZERO + d[6:0];
            else digs[nd] = (caps ? CH_UA : CH_LA) + d[6:0] - 7'd10;
            nd++;
            mag = mag / base;
        end while (mag != 64'd0 && nd < DIGIT_STORE_DEF);

        // zero padding does not count the hex prefix, space padding does
        counted = nd + (has_sign ? 1 : 0) + ((!f_zero && prefix) ? 2 : 0);
        padn    = (lim > counted) ? lim - counted : 0;

        field_len = 0;
        if (!f_zero && !f_left) repeat (padn) put_char(CH_SPACE);
        if (has_sign) put_char(sign_ch);
        if (prefix) begin
            put_char(CH_ZERO);
            put_char(caps ? CH_UX : CH_LX);
        end
        if (f_zero) repeat (padn) put_char(CH_ZERO);
        for (int i = nd - 1; i >= 0; i--) put_char(digs[i]);
        if (!f_zero && f_left) repeat (padn) put_char(CH_SPACE);

        for (int i = 0; i < field_len; i++)
            char_q.push_back({i == field_len - 1, field_buf[i]});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            char_q.delete();
            error_count = 0;
            pend_cnt    = 0;
        end else begin
            // outputs first: a character at this edge belongs to an older request
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: unexpected char %h last %b", $time,
                                 m_tdata[6:0], m_tlast);
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata[6:0] !== want[6:0] || m_tlast !== want[7]) begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                                     $time, want[6:0], want[7], m_tdata[6:0], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready && s_tuser != OP_UNDEF)
                format_field(s_tuser, s_tdata);
            pend_cnt = char_q.size();
        end
    end

endmodule

>>> dv/tb_integer_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_field_formatter
// Drives integer conversion requests into the formatter: a directed set of
// edge cases, then random requests with random gaps and output stalls. The
// checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_integer_field_formatter;
    import iff_pkg::*;

    // flag bits as they sit above the wide bit in tdata
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b00001;
    localparam logic [4:0] F_PLUS  = 5'b00010;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ZERO  = 5'b01000;
    localparam logic [4:0] F_ALT   = 5'b10000;

    localparam int N_RANDOM       = 247;
    localparam int TAIL_ITEMS     = 40;
    localparam int PARK_AT        = 60;
    localparam int DRAIN_AT       = 150;
    localparam int RX_PARK_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam logic [63:0] ALL_ONES = '1;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    int          error_count;
    int          pend_cnt;
    bit          tail_mode = 1'b0;
    bit          park_rx   = 1'b0;

    integer_field_formatter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    iff_char_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .pend_cnt    (pend_cnt)
    );

    always #1 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("tb_integer_field_formatter: FAIL");
        $finish;
    end

    // receiver: random stall bursts, one long park on request
    initial begin : rx_pacing
        int  run_len;
        bit  lvl;
        m_tready = 1'b0;
        forever begin
            if (park_rx) begin
                park_rx = 1'b0;
                lvl     = 1'b0;
                run_len = RX_PARK_CYCLES;
            end else if (tail_mode || $urandom_range(0, 2) != 0) begin
                lvl     = 1'b1;
                run_len = $urandom_range(1, 40);
            end else begin
                lvl     = 1'b0;
                run_len = $urandom_range(1, 13);
            end
            repeat (run_len) begin
                @(negedge aclk);
                m_tready <= lvl;
            end
        end
    end

    // leaves tvalid high on return so back-to-back requests need no toggle
    task automatic send_req(input logic [2:0] kind, input logic [63:0] v, input logic w,
                            input logic [4:0] fl, input logic [5:0] fw);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, fw, fl, w, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic hold_input(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pend_cnt != 0) @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: r = 64'($urandom_range(0, 20));
            1: r = r >> $urandom_range(1, 63);
            2: r = ~(r & 64'h3);
            3: r = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                    $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        logic [5:0] fw;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // every kind code, undefined one included, with the widest values
        for (int k = 0; k < 8; k++)
            send_req(3'(k), ALL_ONES, 1'b1, F_ALT | F_PLUS, 6'd63);

        send_req(OP_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, F_NONE, 6'd0);
        send_req(OP_SDEC, 64'hDEAD_BEEF_8000_0000, 1'b0, F_NONE, 6'd0);
        send_req(OP_SDEC, 64'h8000_0000_0000_0000, 1'b1, F_ZERO, 6'd25);
        send_req(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, F_PLUS, 6'd30);
        send_req(OP_SDEC, 64'd0, 1'b0, F_SPACE | F_LEFT, 6'd5);
        send_req(OP_SDEC, 64'd5, 1'b0, F_PLUS | F_SPACE, 6'd4);
        send_req(OP_SDEC, 64'd123, 1'b0, F_ZERO | F_LEFT, 6'd8);
        send_req(OP_HEXL, 64'd0, 1'b0, F_ALT, 6'd0);
        send_req(OP_HEXL, 64'h0123_4567_89AB_CDEF, 1'b1, F_ALT | F_ZERO, 6'd62);
        send_req(OP_HEXU, 64'hFEDC_BA98_7654_3210, 1'b1, F_ALT, 6'd20);
        send_req(OP_HEXU, 64'h0000_0000_00AB_CDEF, 1'b0, F_ALT | F_LEFT, 6'd63);
        send_req(OP_PTR, 64'hFFFF_FFFF_DEAD_BEEF, 1'b0, F_ZERO, 6'd12);
        send_req(OP_OCT, 64'd8, 1'b0, F_LEFT | F_ALT, 6'd6);
        send_req(OP_BIN, 64'h0000_0000_8000_0001, 1'b0, F_LEFT, 6'd62);
        send_req(OP_BIN, 64'd0, 1'b1, F_ZERO, 6'd63);

        for (int i = 0; i < N_RANDOM; i++) begin
            tail_mode = (i >= N_RANDOM - TAIL_ITEMS);
            // sender keeps offering while the receiver is parked
            if (i == PARK_AT) park_rx = 1'b1;
            if (i == DRAIN_AT) wait_drained();
            fw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 24));
            send_req(3'($urandom_range(0, 7)), pick_value(), 1'($urandom),
                     5'($urandom), fw);
            if (!tail_mode && $urandom_range(0, 3) == 0)
                hold_input($urandom_range(1, 13));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && pend_cnt == 0)
            $display("tb_integer_field_formatter: PASS");
        else
            $display("tb_integer_field_formatter: FAIL");
        $finish;
    end

endmodule
